// File: hdl/assert_macros.svh
// Assertion macros included by heading_pursuit_step_top.
// Assumes signals clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while in reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// File: hdl/hps_pkg.sv
// Types and constants for the heading pursuit step block.
// No dependencies.
`default_nettype none
package hps_pkg;

  localparam int CntW = 5;

  localparam logic signed [17:0] FullTurn = 18'sd23040;
  localparam logic signed [17:0] HalfTurn = 18'sd11520;
  localparam logic signed [24:0] QuarterQ = 25'sd1474560;

  localparam logic [14:0] TurnRateRst  = 15'd5760;
  localparam logic [15:0] MoveSpeedRst = 16'd320;
  localparam logic signed [15:0] PosXRst = 16'sd6400;
  localparam logic signed [15:0] PosYRst = 16'sd4800;

  localparam logic RegTurnRate  = 1'b0;
  localparam logic RegMoveSpeed = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_TURN,
    S_STEP,
    S_CORDIC,
    S_HEAD,
    S_SQRT,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_APPLY,
    S_DONE
  } hps_state_e;

  // atan(2^-i) in 2^-14 degree
  function automatic logic [19:0] hps_atan(input logic [CntW-1:0] idx);
    logic [19:0] r;
    case (idx)
      5'd0:    r = 20'd737280;
      5'd1:    r = 20'd435242;
      5'd2:    r = 20'd229970;
      5'd3:    r = 20'd116736;
      5'd4:    r = 20'd58595;
      5'd5:    r = 20'd29326;
      5'd6:    r = 20'd14667;
      5'd7:    r = 20'd7334;
      5'd8:    r = 20'd3667;
      5'd9:    r = 20'd1833;
      5'd10:   r = 20'd917;
      5'd11:   r = 20'd458;
      5'd12:   r = 20'd229;
      5'd13:   r = 20'd115;
      5'd14:   r = 20'd57;
      5'd15:   r = 20'd29;
      5'd16:   r = 20'd14;
      5'd17:   r = 20'd7;
      5'd18:   r = 20'd4;
      5'd19:   r = 20'd2;
      5'd20:   r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/heading_pursuit_step_top.sv
// Heading pursuit step: CORDIC bearing, rate-limited turn, step toward target.
// Depends on hps_pkg and assert_macros.svh.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, target_x/y, delta  | input items
//  out     | out_valid_o/out_ready_i, heading/pos_x/y  | result items
//  cfg     | psel penable pwrite paddr pwdata prdata   | APB registers
//
// One item walks the states in order, with a multiply, divide and apply
// pass per axis when the target is off the position: one shared 32x16
// multiplier, a bit-serial square root and divider, one step per cycle.
// in_ready_o is high only when idle; a result waits in the output register
// while the next item is taken, and a finished item holds the sequencer
// until that register frees. No clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"
module heading_pursuit_step_top
  import hps_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [15:0] target_x_i,
  input  wire logic signed [15:0] target_y_i,
  input  wire logic        [15:0] delta_time_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [15:0] heading_out_o,
  output      logic signed [15:0] pos_x_out_o,
  output      logic signed [15:0] pos_y_out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [2:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output      logic        [31:0] prdata,
  output      logic               pready
);

  hps_state_e state_q, state_d;

  logic [14:0] turn_rate_q;
  logic [15:0] move_speed_q;
  logic signed [15:0] pos_x_q, pos_y_q, heading_q;
  logic out_valid_q;
  logic signed [15:0] head_out_q, px_out_q, py_out_q;

  logic signed [16:0] dx_q, dy_q;
  logic [15:0] dt_q;
  logic [33:0] sq_q;
  logic [14:0] limit_q;
  logic [31:0] step_q;
  logic signed [25:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic [CntW-1:0] cnt_q;
  logic [48:0] v_q, res_q, bit_q;
  logic [47:0] prod_q;
  logic [32:0] rem_q;
  logic [16:0] nq_q;
  logic ax_q;

  // shared multiplier
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [15:0] absdx, absdy;
  logic signed [16:0] negdx, negdy;
  logic last, nz, do_out;

  assign negdx = -dx_q;
  assign negdy = -dy_q;
  assign absdx = dx_q[16] ? negdx[15:0] : dx_q[15:0];
  assign absdy = dy_q[16] ? negdy[15:0] : dy_q[15:0];
  assign nz    = (dx_q != 17'sd0) || (dy_q != 17'sd0);

  always_comb begin
    mul_a = {16'b0, absdx};
    mul_b = absdx;
    case (state_q)
      S_SQY: begin
        mul_a = {16'b0, absdy};
        mul_b = absdy;
      end
      S_TURN: begin
        mul_a = {17'b0, turn_rate_q};
        mul_b = dt_q;
      end
      S_STEP: begin
        mul_a = {16'b0, move_speed_q};
        mul_b = dt_q;
      end
      S_MUL: begin
        mul_a = step_q;
        mul_b = ax_q ? absdy : absdx;
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // cordic step
  logic signed [25:0] xs, ys;
  logic signed [24:0] atan_s;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign atan_s = 25'(signed'({1'b0, hps_atan(cnt_q)}));

  // cordic pre-rotation
  logic signed [25:0] x0, y0;
  assign x0 = {{3{dx_q[16]}}, dx_q, 6'b0};
  assign y0 = {{3{dy_q[16]}}, dy_q, 6'b0};

  // heading update
  logic signed [24:0] zr;
  logic signed [17:0] brg, err0, err1, err2, lim, h0, h1;
  always_comb begin
    zr = (cz_q + 25'sd128) >>> 8;
    if (zr > 25'(HalfTurn)) begin
      brg = HalfTurn;
    end else if (zr < -25'(HalfTurn)) begin
      brg = -HalfTurn;
    end else begin
      brg = zr[17:0];
    end
    if (!nz) begin
      brg = 18'sd0;
    end
    err0 = brg - 18'(heading_q);
    err1 = (err0 < -HalfTurn) ? err0 + FullTurn : err0;
    err2 = (err1 > HalfTurn) ? err1 - FullTurn : err1;
    lim  = signed'({3'b0, limit_q});
    if (err2 > 18'sd0) begin
      if (err2 > lim) begin
        err2 = lim;
      end
    end else begin
      if (err2 < -lim) begin
        err2 = -lim;
      end
    end
    h0 = 18'(heading_q) + err2;
    h1 = (h0 > FullTurn) ? h0 - FullTurn : h0;
    if (h1 < -FullTurn) begin
      h1 = h1 + FullTurn;
    end
  end

  // square root step
  logic [49:0] sq_t;
  logic sq_ge;
  assign sq_t  = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_ge = {1'b0, v_q} >= sq_t;

  // division step
  logic [32:0] den;
  logic [33:0] dr, dsub;
  logic dge;
  logic [48:0] num;
  assign den  = {res_q[24:0], 8'b0};
  assign dr   = {rem_q, nq_q[16]};
  assign dge  = dr >= {1'b0, den};
  assign dsub = dr - {1'b0, den};
  assign num  = {1'b0, prod_q} + {17'b0, res_q[24:0], 7'b0};

  // position update
  logic signed [18:0] pcur, pmov, psum;
  logic signed [15:0] psat;
  always_comb begin
    pcur = 19'(ax_q ? pos_y_q : pos_x_q);
    pmov = signed'({2'b0, nq_q});
    if (ax_q ? dy_q[16] : dx_q[16]) begin
      pmov = -pmov;
    end
    psum = pcur + pmov;
    if (psum > 19'sd32767) begin
      psat = 16'sh7fff;
    end else if (psum < -19'sd32768) begin
      psat = 16'sh8000;
    end else begin
      psat = psum[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    last    = 1'b0;
    do_out  = 1'b0;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_TURN;
      S_TURN:   state_d = S_STEP;
      S_STEP:   state_d = S_CORDIC;
      S_CORDIC: begin
        last = cnt_q == CntW'(CORDIC_STEPS - 1);
        if (last) state_d = S_HEAD;
      end
      S_HEAD:   state_d = S_SQRT;
      S_SQRT: begin
        last = cnt_q == 5'd24;
        if (last) state_d = nz ? S_MUL : S_DONE;
      end
      S_MUL:    state_d = S_LOAD;
      S_LOAD:   state_d = S_DIV;
      S_DIV: begin
        last = cnt_q == 5'd16;
        if (last) state_d = S_APPLY;
      end
      S_APPLY:  state_d = ax_q ? S_DONE : S_MUL;
      S_DONE: begin
        do_out = !out_valid_q || out_ready_i;
        if (do_out) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign heading_out_o = head_out_q;
  assign pos_x_out_o   = px_out_q;
  assign pos_y_out_o   = py_out_q;
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? {16'b0, move_speed_q} : {17'b0, turn_rate_q};

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      turn_rate_q  <= TurnRateRst;
      move_speed_q <= MoveSpeedRst;
      pos_x_q      <= PosXRst;
      pos_y_q      <= PosYRst;
      heading_q    <= '0;
      cnt_q        <= '0;
      ax_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite) begin
        if (paddr[2] == RegTurnRate) begin
          turn_rate_q <= pwdata[14:0];
        end else begin
          move_speed_q <= pwdata[15:0];
        end
      end
      if (state_q == S_CORDIC || state_q == S_SQRT || state_q == S_DIV) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
      if (state_q == S_IDLE) begin
        ax_q <= 1'b0;
      end
      if (state_q == S_HEAD) begin
        heading_q <= h1[15:0];
      end
      if (state_q == S_APPLY) begin
        ax_q <= 1'b1;
        if (ax_q) begin
          pos_y_q <= psat;
        end else begin
          pos_x_q <= psat;
        end
      end
      if (do_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dx_q <= 17'(target_x_i) - 17'(pos_x_q);
        dy_q <= 17'(target_y_i) - 17'(pos_y_q);
        dt_q <= delta_time_i;
      end
      S_SQX: begin
        sq_q <= 34'(prod);
        cx_q <= x0;
        cy_q <= y0;
        cz_q <= '0;
        if (x0 < 0) begin
          if (y0 >= 0) begin
            cx_q <= y0;
            cy_q <= -x0;
            cz_q <= QuarterQ;
          end else begin
            cx_q <= -y0;
            cy_q <= x0;
            cz_q <= -QuarterQ;
          end
        end
      end
      S_SQY:  sq_q <= sq_q + 34'(prod);
      S_TURN: limit_q <= prod[30:16];
      S_STEP: step_q <= prod[31:0];
      S_CORDIC: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_s;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_s;
        end
      end
      S_HEAD: begin
        v_q   <= {sq_q[32:0], 16'b0};
        res_q <= '0;
        bit_q <= 49'd1 << 48;
      end
      S_SQRT: begin
        if (sq_ge) begin
          v_q   <= v_q - sq_t[48:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_MUL: prod_q <= prod;
      S_LOAD: begin
        rem_q <= {1'b0, num[48:17]};
        nq_q  <= num[16:0];
      end
      S_DIV: begin
        rem_q <= dge ? dsub[32:0] : dr[32:0];
        nq_q  <= {nq_q[15:0], dge};
      end
      default: ;
    endcase
    if (do_out) begin
      head_out_q <= heading_q;
      px_out_q   <= pos_x_q;
      py_out_q   <= pos_y_q;
    end
  end

  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `ASSERT_CLK(a_rem_below_den, (state_q == S_DIV) |-> (rem_q < den))
  `ASSERT_CLK(a_heading_range, (heading_q <= 16'sd23040) && (heading_q >= -16'sd23040))

endmodule
`default_nettype wire

// File: tb/heading_pursuit_step_checker.sv
// Checker for heading_pursuit_step_top: watches the item and register ports,
// predicts each result with a fixed-point pursuit model and compares in order.
// Depends on hps_pkg for register indexes and turn constants.
`timescale 1ns / 1ps
module heading_pursuit_step_checker
  import hps_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic signed [15:0] target_x_i,
  input logic signed [15:0] target_y_i,
  input logic        [15:0] delta_time_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] heading_out_i,
  input logic signed [15:0] pos_x_out_i,
  input logic signed [15:0] pos_y_out_i,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic        [2:0]  paddr,
  input logic        [31:0] pwdata,
  input logic               pready,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } pose_t;

  pose_t pose_q[$];
  logic signed [15:0] cur_x, cur_y, cur_head;
  logic [14:0] turn_rate;
  logic [15:0] move_speed;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q14(int i);
    longint t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                      3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
    return t[i];
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 64;
    y = dy * 64;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QuarterQ;
      end else begin
        t = x; x = -y; y = t; z = -QuarterQ;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_q14(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_q14(i);
      end
    end
    z = fshr(z + 128, 8);
    if (z > HalfTurn) z = HalfTurn;
    if (z < -HalfTurn) z = -HalfTurn;
    return z;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint axis_step(longint unsigned stp, longint d, longint unsigned den);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = (stp * mag + den / 2) / den;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic predict_pose(input logic signed [15:0] tx, ty, input logic [15:0] dt);
    longint dx, dy, err, lim, h;
    longint unsigned len, stp, den;
    pose_t p;
    dx = longint'(tx) - cur_x;
    dy = longint'(ty) - cur_y;
    err = bearing(dx, dy) - cur_head;
    if (err < -HalfTurn) err += FullTurn;
    if (err > HalfTurn) err -= FullTurn;
    lim = (longint'(turn_rate) * dt) >> 16;
    if (err > 0) begin
      if (err > lim) err = lim;
    end else if (err < -lim) err = -lim;
    h = cur_head + err;
    if (h > FullTurn) h -= FullTurn;
    if (h < -FullTurn) h += FullTurn;
    cur_head = h[15:0];
    if (dx != 0 || dy != 0) begin
      len = root64(longint'(dx * dx + dy * dy) << 16);
      stp = longint'(move_speed) * dt;
      den = len * 256;
      cur_x = clamp16(cur_x + axis_step(stp, dx, den));
      cur_y = clamp16(cur_y + axis_step(stp, dy, den));
    end
    p.heading = cur_head;
    p.pos_x = cur_x;
    p.pos_y = cur_y;
    pose_q.push_back(p);
  endtask

  assign pending_o = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      pose_q.delete();
      cur_x = PosXRst;
      cur_y = PosYRst;
      cur_head = '0;
      turn_rate = TurnRateRst;
      move_speed = MoveSpeedRst;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegTurnRate) turn_rate = pwdata[14:0];
        else move_speed = pwdata[15:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (pose_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          e = pose_q.pop_front();
          if (e.heading !== heading_out_i || e.pos_x !== pos_x_out_i ||
              e.pos_y !== pos_y_out_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: exp h=%0d x=%0d y=%0d got h=%0d x=%0d y=%0d",
                       e.heading, e.pos_x, e.pos_y, heading_out_i, pos_x_out_i,
                       pos_y_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_pose(target_x_i, target_y_i, delta_time_i);
    end
  end

endmodule

// File: tb/heading_pursuit_step_top_tb.sv
// Testbench top for heading_pursuit_step_top: makes items, register writes and
// back-pressure, and gives the verdict. Depends on hps_pkg, the DUT and the checker.
`timescale 1ns / 1ps
module heading_pursuit_step_top_tb;
  import hps_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic signed [15:0] target_x_i = '0, target_y_i = '0;
  logic [15:0] delta_time_i = '0;
  logic signed [15:0] heading_out_o, pos_x_out_o, pos_y_out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int send_idle = 18, recv_idle = 50;
  bit hold_recv = 1'b0;
  int quiet_cycles = 0;
  logic signed [15:0] aim_x = 16'sd6400, aim_y = 16'sd4800;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  heading_pursuit_step_top u_dut (.*);

  heading_pursuit_step_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .target_x_i, .target_y_i,
    .delta_time_i, .out_valid_i(out_valid_o), .out_ready_i, .heading_out_i(heading_out_o),
    .pos_x_out_i(pos_x_out_o), .pos_y_out_i(pos_y_out_o), .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (hold_recv) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("** heading_pursuit_step_top: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(input logic regsel, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {regsel, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_item(input logic signed [15:0] tx, ty, input logic [15:0] dt);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= tx; target_y_i <= ty; delta_time_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_item();
    logic [15:0] dt;
    int k;
    k = $urandom_range(9);
    dt = (k < 2) ? 16'($urandom) : 16'($urandom_range(4000));
    if (k < 6) begin
      aim_x = aim_x + $signed(16'($urandom_range(800))) - 16'sd400;
      aim_y = aim_y + $signed(16'($urandom_range(800))) - 16'sd400;
      send_item(aim_x, aim_y, dt);
    end else if (k < 9) send_item(16'($urandom), 16'($urandom), dt);
    else send_item(pos_x_out_o, 16'($urandom), dt);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send_item(16'sd6400, 16'sd4800, 16'hffff);
    send_item(16'sd6400, 16'sd9000, 16'd1000);
    send_item(16'sd9000, 16'sd4800, 16'd1000);
    send_item(-16'sd32768, 16'sd4800, 16'hffff);
    send_item(16'sd32767, 16'sd32767, 16'hffff);
    send_item(-16'sd32768, -16'sd32768, 16'd0);
    send_item(16'sd0, -16'sd32768, 16'd30000);
    drain();
    reg_write(RegTurnRate, 32'd23040);
    reg_write(RegMoveSpeed, 32'hffff);
    send_item(-16'sd32768, 16'sd0, 16'hffff);
    send_item(16'sd32767, 16'sd0, 16'hffff);
    send_item(16'sd32767, 16'sd32767, 16'hffff);
    send_item(-16'sd32768, 16'sd32767, 16'h8000);
    send_item(-16'sd100, -16'sd32768, 16'h5555);
    drain();
    reg_write(RegTurnRate, 32'hffff_ffff);
    reg_write(RegMoveSpeed, 32'd0);
    send_item(16'sd0, 16'sd100, 16'hffff);
    send_item(16'sd0, -16'sd100, 16'hffff);
    send_item(16'sd5, -16'sd7, 16'h2aaa);
    drain();
    reg_write(RegTurnRate, 32'd0);
    reg_write(RegMoveSpeed, 32'd1);
    send_item(16'sd3000, 16'sd3000, 16'hffff);
    drain();
    reg_write(RegTurnRate, 32'(TurnRateRst));
    reg_write(RegMoveSpeed, 32'd2000);
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      repeat (6) random_item();
    join
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      reg_write(RegTurnRate, $urandom_range(23040));
      reg_write(RegMoveSpeed, $urandom_range(65535));
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 50 : 0;
      recv_idle = (ph == 0) ? 50 : (ph == 1) ? 18 : 0;
      repeat (640) random_item();
    end
    drain();
    if (fail_count == 0) $display("** heading_pursuit_step_top: PASSED **");
    else $display("** heading_pursuit_step_top: FAILED **");
    $finish;
  end

endmodule
